// ===== rtl/core/mvaa_pkg.sv =====
// shared types, register codes and constants of the motion vector activity aggregator
package mvaa_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_NORM = 2'd0;
    localparam logic [1:0] REG_MAX_NORM = 2'd1;
    localparam logic [1:0] REG_EXP_GAIN = 2'd2;

    // number of direction sums (four per half)
    localparam int NUM_DIR = 8;

    // shared multiplier operand width
    localparam int MUL_W = 31;

    // one in q1.30 and the taylor start term count
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
    localparam logic [3:0]  TAYLOR_K = 4'd12;
    localparam logic [11:0] EXP_SAT  = 12'd12;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_N_AX,
        S_N_AY,
        S_N_MIN,
        S_N_MAX,
        S_N_ACC,
        S_AVG,
        S_AVG_W,
        S_RES,
        S_SQ_P,
        S_SQ_PR,
        S_SQ_M,
        S_SQ_MR,
        S_SQ_DW,
        S_SQ_E,
        S_SQ_ER,
        S_PUSH
    } t_state;

    // exp(-n) in q1.30 for integer n
    function automatic logic [30:0] exp_neg_int(input logic [3:0] n);
        logic [30:0] v;
        case (n)
            4'd0:    v = 31'd1073741824;
            4'd1:    v = 31'd395007542;
            4'd2:    v = 31'd145315154;
            4'd3:    v = 31'd53458456;
            4'd4:    v = 31'd19666268;
            4'd5:    v = 31'd7234816;
            4'd6:    v = 31'd2661540;
            4'd7:    v = 31'd979126;
            4'd8:    v = 31'd360200;
            4'd9:    v = 31'd132510;
            4'd10:   v = 31'd48748;
            4'd11:   v = 31'd17933;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mvaa_mul.sv =====
// shared unsigned multiplier with registered product
module mvaa_mul (
    input  logic                          i_clk,
    input  logic [mvaa_pkg::MUL_W-1:0]    i_a,
    input  logic [mvaa_pkg::MUL_W-1:0]    i_b,
    output logic [2*mvaa_pkg::MUL_W-1:0]  o_p
);

    logic [2*mvaa_pkg::MUL_W-1:0] r_p;

    // product register
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/mvaa_div.sv =====
// shared restoring divider, one quotient bit per cycle
module mvaa_div #(
    parameter int DVD_W = 30,
    parameter int DVS_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W:0]   w_trial;
    logic             w_ge;

    // trial subtract of the next dividend bit
    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== rtl/core/motion_vector_activity_aggregator.sv =====
// top level: stream ports, frame sums and the sequencer around the shared units
// Each motion vector passes a ready state, then four multiplier passes for the
// norm test and one accumulate state. On the last point of a frame the block
// then runs the frame close-out on one shared multiplier and one bit-serial
// divider: eight averages, then eight squashes. Input is not ready during the
// whole sequence. The result waits in an output register; a following frame
// only stalls if it finishes before that is taken.
module motion_vector_activity_aggregator #(
    parameter int MAX_POINTS = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data,
    // input vectors
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x[11:0], center_x[23:12], disp_x[39:24], disp_y[55:40]
    input  logic [55:0]  s_axis_tdata,
    // mask_pass[0]
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    // frame results
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // left_half_leftward[15:0], left_half_rightward[31:16], left_half_upward[47:32],
    // left_half_downward[63:48], right_half_leftward[79:64],
    // right_half_rightward[95:80], right_half_upward[111:96],
    // right_half_downward[127:112]
    output logic [127:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = CNT_W + 16;
    localparam int DVD_W = (SUM_W > 30) ? SUM_W : 30;
    localparam int DVS_W = (CNT_W > 4) ? CNT_W : 4;
    localparam int MW    = mvaa_pkg::MUL_W;

    mvaa_pkg::t_state r_state, n_state;

    logic [15:0] r_min_norm, r_max_norm, r_exp_gain;

    // latched item
    logic              r_half, r_pass, r_last, r_nx, r_ny;
    logic [15:0]       r_ax, r_ay;
    logic [32:0]       r_n2;
    logic              r_gt;

    // frame state
    logic [SUM_W-1:0]  r_sum [mvaa_pkg::NUM_DIR];
    logic [CNT_W-1:0]  r_cnt [2];
    logic [15:0]       r_val [mvaa_pkg::NUM_DIR];
    logic [2:0]        r_idx;

    // squash loop state
    logic [29:0]       r_t;
    logic [30:0]       r_acc;
    logic [3:0]        r_n;
    logic [3:0]        r_k;

    logic              r_out_valid;
    logic [127:0]      r_out;

    // shared units
    logic [MW-1:0]     w_ma, w_mb;
    logic [2*MW-1:0]   w_mp;
    logic              w_div_start, w_div_done;
    logic [DVD_W-1:0]  w_dvd, w_quot;
    logic [DVS_W-1:0]  w_dvs;

    logic              w_accept, w_keep, w_last_idx;
    logic [2:0]        w_ix, w_iy;
    logic [CNT_W-1:0]  w_cnt_sel;
    logic [31:0]       w_e;
    logic [17:0]       w_rnd;
    logic [15:0]       w_sq;
    logic [31:0]       w_p;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_last_idx = r_idx == 3'(mvaa_pkg::NUM_DIR - 1);
    assign w_cnt_sel  = r_cnt[r_idx[2]];
    assign w_keep     = r_pass && r_gt && (r_n2 < {1'b0, w_mp[31:0]})
                        && (r_cnt[r_half] < CNT_W'(MAX_POINTS));
    assign w_ix       = {r_half, 1'b0, ~r_nx};
    assign w_iy       = {r_half, 1'b1, ~r_ny};
    assign w_p        = w_mp[31:0];

    // rounding of the final exponential term
    assign w_e   = w_mp[61:30];
    assign w_rnd = 18'((w_e + 32'd8192) >> 14);
    assign w_sq  = (w_rnd == 18'd0) ? 16'hFFFF : 16'(18'd65536 - w_rnd);

    mvaa_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_mp)
    );

    mvaa_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mvaa_pkg::S_IDLE:  if (w_accept) n_state = mvaa_pkg::S_N_AX;
            mvaa_pkg::S_N_AX:  n_state = mvaa_pkg::S_N_AY;
            mvaa_pkg::S_N_AY:  n_state = mvaa_pkg::S_N_MIN;
            mvaa_pkg::S_N_MIN: n_state = mvaa_pkg::S_N_MAX;
            mvaa_pkg::S_N_MAX: n_state = mvaa_pkg::S_N_ACC;
            mvaa_pkg::S_N_ACC: n_state = r_last ? mvaa_pkg::S_AVG : mvaa_pkg::S_IDLE;
            mvaa_pkg::S_AVG: begin
                if (w_cnt_sel != '0) n_state = mvaa_pkg::S_AVG_W;
                else if (w_last_idx) n_state = mvaa_pkg::S_RES;
            end
            mvaa_pkg::S_AVG_W: begin
                if (w_div_done) n_state = w_last_idx ? mvaa_pkg::S_RES : mvaa_pkg::S_AVG;
            end
            mvaa_pkg::S_RES:   n_state = mvaa_pkg::S_SQ_P;
            mvaa_pkg::S_SQ_P:  n_state = mvaa_pkg::S_SQ_PR;
            mvaa_pkg::S_SQ_PR: begin
                if (w_p != '0 && w_p[31:20] < mvaa_pkg::EXP_SAT) n_state = mvaa_pkg::S_SQ_M;
                else n_state = w_last_idx ? mvaa_pkg::S_PUSH : mvaa_pkg::S_SQ_P;
            end
            mvaa_pkg::S_SQ_M:  n_state = mvaa_pkg::S_SQ_MR;
            mvaa_pkg::S_SQ_MR: n_state = mvaa_pkg::S_SQ_DW;
            mvaa_pkg::S_SQ_DW: begin
                if (w_div_done) n_state = (r_k == 4'd1) ? mvaa_pkg::S_SQ_E : mvaa_pkg::S_SQ_M;
            end
            mvaa_pkg::S_SQ_E:  n_state = mvaa_pkg::S_SQ_ER;
            mvaa_pkg::S_SQ_ER: n_state = w_last_idx ? mvaa_pkg::S_PUSH : mvaa_pkg::S_SQ_P;
            mvaa_pkg::S_PUSH:  if (!r_out_valid) n_state = mvaa_pkg::S_IDLE;
            default:           n_state = mvaa_pkg::S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        s_axis_tready = 1'b0;
        w_ma          = '0;
        w_mb          = '0;
        w_div_start   = 1'b0;
        w_dvd         = DVD_W'(r_sum[r_idx]);
        w_dvs         = DVS_W'(w_cnt_sel);
        case (r_state)
            mvaa_pkg::S_IDLE:  s_axis_tready = 1'b1;
            mvaa_pkg::S_N_AX:  begin w_ma = MW'(r_ax); w_mb = MW'(r_ax); end
            mvaa_pkg::S_N_AY:  begin w_ma = MW'(r_ay); w_mb = MW'(r_ay); end
            mvaa_pkg::S_N_MIN: begin w_ma = MW'(r_min_norm); w_mb = MW'(r_min_norm); end
            mvaa_pkg::S_N_MAX: begin w_ma = MW'(r_max_norm); w_mb = MW'(r_max_norm); end
            mvaa_pkg::S_AVG:   w_div_start = w_cnt_sel != '0;
            mvaa_pkg::S_SQ_P:  begin w_ma = MW'(r_val[r_idx]); w_mb = MW'(r_exp_gain); end
            mvaa_pkg::S_SQ_M:  begin w_ma = MW'(r_t); w_mb = r_acc; end
            mvaa_pkg::S_SQ_MR: begin
                w_div_start = 1'b1;
                w_dvd       = DVD_W'(w_mp[59:30]);
                w_dvs       = DVS_W'(r_k);
            end
            mvaa_pkg::S_SQ_E:  begin w_ma = mvaa_pkg::exp_neg_int(r_n); w_mb = r_acc; end
            default: ;
        endcase
    end

    // state, output handshake and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mvaa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_min_norm  <= 16'd256;
            r_max_norm  <= 16'd65535;
            r_exp_gain  <= 16'd4096;
        end else begin
            r_state <= n_state;
            if (r_state == mvaa_pkg::S_PUSH && !r_out_valid) r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mvaa_pkg::REG_MIN_NORM: r_min_norm <= i_cfg_data;
                    mvaa_pkg::REG_MAX_NORM: r_max_norm <= i_cfg_data;
                    mvaa_pkg::REG_EXP_GAIN: r_exp_gain <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // frame sums and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mvaa_pkg::NUM_DIR; i++) r_sum[i] <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
        end else if (r_state == mvaa_pkg::S_N_ACC && w_keep) begin
            for (int i = 0; i < mvaa_pkg::NUM_DIR; i++) begin
                if (3'(i) == w_ix) r_sum[i] <= r_sum[i] + SUM_W'(r_ax);
                else if (3'(i) == w_iy) r_sum[i] <= r_sum[i] + SUM_W'(r_ay);
            end
            r_cnt[r_half] <= r_cnt[r_half] + 1'b1;
        end else if (r_state == mvaa_pkg::S_PUSH && !r_out_valid) begin
            for (int i = 0; i < mvaa_pkg::NUM_DIR; i++) r_sum[i] <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mvaa_pkg::S_IDLE: begin
                r_half <= !(s_axis_tdata[11:0] < s_axis_tdata[23:12]);
                r_nx   <= s_axis_tdata[39];
                r_ny   <= s_axis_tdata[55];
                r_ax   <= s_axis_tdata[39] ? 16'(-s_axis_tdata[39:24]) : s_axis_tdata[39:24];
                r_ay   <= s_axis_tdata[55] ? 16'(-s_axis_tdata[55:40]) : s_axis_tdata[55:40];
                r_pass <= s_axis_tuser;
                r_last <= s_axis_tlast;
                r_idx  <= '0;
            end
            mvaa_pkg::S_N_AY:  r_n2 <= 33'(w_p);
            mvaa_pkg::S_N_MIN: r_n2 <= r_n2 + 33'(w_p);
            mvaa_pkg::S_N_MAX: r_gt <= r_n2 > {1'b0, w_p};
            mvaa_pkg::S_AVG: begin
                if (w_cnt_sel == '0) begin
                    r_val[r_idx] <= '0;
                    r_idx        <= r_idx + 1'b1;
                end
            end
            mvaa_pkg::S_AVG_W: begin
                if (w_div_done) begin
                    r_val[r_idx] <= w_quot[15:0];
                    r_idx        <= r_idx + 1'b1;
                end
            end
            mvaa_pkg::S_RES: begin
                // mutual exclusion per pair, second of the pair wins a tie
                for (int j = 0; j < mvaa_pkg::NUM_DIR; j += 2) begin
                    if (r_val[j] > r_val[j+1]) r_val[j+1] <= '0;
                    else r_val[j] <= '0;
                end
                r_idx <= '0;
            end
            mvaa_pkg::S_SQ_PR: begin
                r_t   <= {w_p[19:0], 10'd0};
                r_n   <= w_p[23:20];
                r_acc <= mvaa_pkg::ONE_Q30;
                r_k   <= mvaa_pkg::TAYLOR_K;
                if (w_p == '0) begin
                    r_val[r_idx] <= '0;
                    r_idx        <= r_idx + 1'b1;
                end else if (!(w_p[31:20] < mvaa_pkg::EXP_SAT)) begin
                    r_val[r_idx] <= 16'hFFFF;
                    r_idx        <= r_idx + 1'b1;
                end
            end
            mvaa_pkg::S_SQ_DW: begin
                if (w_div_done) begin
                    r_acc <= mvaa_pkg::ONE_Q30 - 31'(w_quot);
                    r_k   <= r_k - 1'b1;
                end
            end
            mvaa_pkg::S_SQ_ER: begin
                r_val[r_idx] <= w_sq;
                r_idx        <= r_idx + 1'b1;
            end
            mvaa_pkg::S_PUSH: begin
                if (!r_out_valid) begin
                    for (int i = 0; i < mvaa_pkg::NUM_DIR; i++) r_out[16*i +: 16] <= r_val[i];
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // divider completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == mvaa_pkg::S_AVG_W || r_state == mvaa_pkg::S_SQ_DW))
        else $error("divider done outside a wait state");

    // half counts stay within the saturation limit
    a_cnt_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt[0] <= CNT_W'(MAX_POINTS) && r_cnt[1] <= CNT_W'(MAX_POINTS))
        else $error("half count above limit");

    // frame state is empty once a result is handed to the output register
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mvaa_pkg::S_PUSH && !r_out_valid) |=>
        (r_cnt[0] == '0 && r_cnt[1] == '0 && m_axis_tvalid))
        else $error("frame state not cleared on result");

    // after resolution each opposing pair holds at most one nonzero value
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mvaa_pkg::S_RES |=>
        ((r_val[0] == '0 || r_val[1] == '0) && (r_val[2] == '0 || r_val[3] == '0) &&
         (r_val[4] == '0 || r_val[5] == '0) && (r_val[6] == '0 || r_val[7] == '0)))
        else $error("pair not resolved");

endmodule
